@@ src/stdf_pkg.sv @@
// shared types, codes and helpers for the security token deframer
package stdf_pkg;

  localparam int unsigned ResMax = 4;
  localparam int unsigned QDepth = 5;
  localparam logic [31:0] MaxPlainReset = 32'h0100_0000;

  localparam logic [7:0] RecTypeLo = 8'd20;
  localparam logic [7:0] RecTypeHi = 8'd26;
  localparam logic [7:0] RecTypeT26 = 8'd26;
  localparam logic [32:0] TrailerLen = 33'd12;
  localparam logic [14:0] Ssl2Overhead = 15'd3;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_FIFTH   = 2'd1,
    PH_TRAILER = 2'd2,
    PH_BODY    = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,
    KIND_SSL3  = 2'd1,
    KIND_SSL2  = 2'd2,
    KIND_T26   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_BYTE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_EARLY = 2'd2,
    ST_BAD   = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_last;
    status_e    status;
  } res_t;

  typedef res_t [ResMax-1:0] res_vec_t;

  typedef struct packed {
    phase_e      phase;
    logic [1:0]  hdr_cnt;
    logic [32:0] rem;
    kind_e       kind;
    logic [31:0] tshift;
  } dfr_state_t;

  function automatic res_t mk_res(logic [7:0] b, logic last, status_e st);
    res_t r;
    r.out_byte = b;
    r.is_last  = last;
    r.status   = st;
    return r;
  endfunction

endpackage

@@ src/stdf_step.sv @@
// combinational step: next deframer state and the results of one item
module stdf_step import stdf_pkg::*; (
  input  dfr_state_t       cur_i,
  input  logic [3:0][7:0]  hdr_i,
  input  logic [7:0]       byte_i,
  input  logic             end_i,
  input  logic [31:0]      max_len_i,
  output dfr_state_t       nxt_o,
  output logic             hdr_we_o,
  output logic [2:0]       res_cnt_o,
  output res_vec_t         res_o
);

  logic [7:0]  b0, b1, b2;
  logic        tls_like, ssl2_like;
  logic [14:0] len2;
  logic [31:0] len;
  logic [15:0] dsize;
  logic [31:0] tshift_new;
  logic [32:0] rem_dec;

  assign b0 = hdr_i[0];
  assign b1 = hdr_i[1];
  assign b2 = hdr_i[2];
  assign tls_like = (b0 >= RecTypeLo) && (b0 <= RecTypeHi) &&
                    ((b1 == 8'd3) || ((b1 == 8'd2) && (b2 == 8'd0)));
  assign ssl2_like = b0[7] && (b2 == 8'd1);
  assign len2 = {b0[6:0], b1};
  assign len = {b0, b1, b2, byte_i};
  assign rem_dec = cur_i.rem - 33'd1;
  assign dsize = (cur_i.kind == KIND_SSL2) ? {1'b0, len2 - Ssl2Overhead}
                                           : {hdr_i[3], byte_i};
  assign tshift_new = (cur_i.rem <= 33'd4) ? {cur_i.tshift[23:0], byte_i} : cur_i.tshift;

  always_comb begin
    nxt_o = cur_i;
    hdr_we_o = 1'b0;
    res_cnt_o = 3'd0;
    res_o = '0;
    if (end_i) begin
      if (!((cur_i.phase == PH_HEADER) && (cur_i.hdr_cnt == 2'd0))) begin
        nxt_o.phase = PH_HEADER;
        nxt_o.hdr_cnt = 2'd0;
        res_o[0] = mk_res(8'd0, 1'b1, ST_EARLY);
        res_cnt_o = 3'd1;
      end
    end else begin
      case (cur_i.phase)
        PH_HEADER: begin
          hdr_we_o = 1'b1;
          if (cur_i.hdr_cnt != 2'd3) begin
            nxt_o.hdr_cnt = cur_i.hdr_cnt + 2'd1;
          end else begin
            nxt_o.hdr_cnt = 2'd0;
            if (tls_like || (ssl2_like && (len2 >= Ssl2Overhead))) begin
              // record header is passed through in one go
              if (tls_like) begin
                nxt_o.kind = (b0 == RecTypeT26) ? KIND_T26 : KIND_SSL3;
              end else begin
                nxt_o.kind = KIND_SSL2;
              end
              res_o[0] = mk_res(b0, 1'b0, ST_BYTE);
              res_o[1] = mk_res(b1, 1'b0, ST_BYTE);
              res_o[2] = mk_res(b2, 1'b0, ST_BYTE);
              res_o[3] = mk_res(byte_i, 1'b0, ST_BYTE);
              res_cnt_o = 3'd4;
              nxt_o.phase = PH_FIFTH;
            end else if (ssl2_like) begin
              res_o[0] = mk_res(8'd0, 1'b1, ST_BAD);
              res_cnt_o = 3'd1;
            end else begin
              nxt_o.kind = KIND_PLAIN;
              res_cnt_o = 3'd1;
              if (len > max_len_i) begin
                res_o[0] = mk_res(8'd0, 1'b1, ST_BAD);
              end else if (len == 32'd0) begin
                res_o[0] = mk_res(8'd0, 1'b1, ST_EMPTY);
              end else begin
                res_cnt_o = 3'd0;
                nxt_o.rem = {1'b0, len};
                nxt_o.phase = PH_BODY;
              end
            end
          end
        end
        PH_FIFTH: begin
          res_cnt_o = 3'd1;
          res_o[0] = mk_res(byte_i, 1'b0, ST_BYTE);
          if (cur_i.kind == KIND_T26) begin
            nxt_o.rem = {17'd0, dsize} + TrailerLen;
            nxt_o.tshift = 32'd0;
            nxt_o.phase = PH_TRAILER;
          end else if (dsize == 16'd0) begin
            res_o[0].is_last = 1'b1;
            nxt_o.phase = PH_HEADER;
            nxt_o.hdr_cnt = 2'd0;
          end else begin
            nxt_o.rem = {17'd0, dsize};
            nxt_o.phase = PH_BODY;
          end
        end
        PH_TRAILER: begin
          res_cnt_o = 3'd1;
          res_o[0] = mk_res(byte_i, 1'b0, ST_BYTE);
          nxt_o.tshift = tshift_new;
          nxt_o.rem = rem_dec;
          if (rem_dec == 33'd0) begin
            if (tshift_new == 32'd0) begin
              res_o[0].is_last = 1'b1;
              nxt_o.phase = PH_HEADER;
              nxt_o.hdr_cnt = 2'd0;
            end else begin
              // last four trailer bytes give the further body length
              nxt_o.rem = {1'b0, tshift_new};
              nxt_o.phase = PH_BODY;
            end
          end
        end
        default: begin
          res_cnt_o = 3'd1;
          res_o[0] = mk_res(byte_i, 1'b0, ST_BYTE);
          if (cur_i.rem <= 33'd1) begin
            res_o[0].is_last = 1'b1;
            nxt_o.rem = 33'd0;
            nxt_o.phase = PH_HEADER;
            nxt_o.hdr_cnt = 2'd0;
          end else begin
            nxt_o.rem = rem_dec;
          end
        end
      endcase
    end
  end

endmodule

@@ src/stdf_outq.sv @@
// result queue: takes up to four results per cycle while ready_o is high, hands out one
module stdf_outq import stdf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [2:0] push_cnt_i,
  input  res_vec_t   push_res_i,
  output logic       ready_o,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  output res_t       m_res_o
);

  res_t       slot_q [QDepth];
  res_t       slot_d [QDepth];
  logic [2:0] cnt_q, cnt_d;
  logic [2:0] base;
  logic [2:0] idx;
  logic       pop;

  assign pop = m_valid_o && m_ready_i;
  assign base = cnt_q - {2'd0, pop};
  // room for a full burst once the pop of this cycle is counted
  assign ready_o = (base <= 3'd1);
  assign m_valid_o = (cnt_q != 3'd0);
  assign m_res_o = slot_q[0];

  always_comb begin
    idx = 3'd0;
    for (int i = 0; i < QDepth; i++) begin
      if (pop && (i < QDepth - 1)) begin
        slot_d[i] = slot_q[(i < QDepth - 1) ? i + 1 : i];
      end else begin
        slot_d[i] = slot_q[i];
      end
      idx = 3'(i) - base;
      if (push_i && (3'(i) >= base) && (idx < push_cnt_i)) begin
        slot_d[i] = push_res_i[idx[1:0]];
      end
    end
    cnt_d = base + (push_i ? push_cnt_i : 3'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDepth; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(QDepth))
    else $error("result queue over capacity");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> ({1'b0, base} + {1'b0, push_cnt_i} <= 4'(QDepth)))
    else $error("push without room in result queue");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_i) |=> (cnt_q == $past(cnt_q) - 3'd1))
    else $error("result queue count lost track on pop");

endmodule

@@ src/security_token_deframer.sv @@
// top level of the security token deframer
// Byte-stream deframer: one input item (a byte, or the stream end flag on tlast) is taken
// per cycle while the queue has room, and each token byte is buffered in a five-entry result
// queue. Plain tokens have their four-byte big-endian length stripped; SSL/TLS-like records
// pass through whole. The fourth byte of a record header yields four results at once,
// so the input then stalls while the queue drains; otherwise the sustained rate is one item
// per cycle while the receiver keeps up, set by the combinational step logic and the
// one-result-per-cycle output port. No clearing pass is needed after reset.
module security_token_deframer import stdf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,   // max_plain_length
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tlast,  // stream_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [7:0] out_byte, [9:8] status, rest zero
  output logic        m_axis_tlast   // is_last
);

  dfr_state_t      st_q, st_d;
  logic [3:0][7:0] hdr_q;
  logic [31:0]     max_len_q;
  logic            hdr_we;
  logic [2:0]      res_cnt;
  res_vec_t        res;
  logic            accept;
  res_t            m_res;

  assign accept = s_axis_tvalid && s_axis_tready;

  stdf_step u_step (
    .cur_i     (st_q),
    .hdr_i     (hdr_q),
    .byte_i    (s_axis_tdata),
    .end_i     (s_axis_tlast),
    .max_len_i (max_len_q),
    .nxt_o     (st_d),
    .hdr_we_o  (hdr_we),
    .res_cnt_o (res_cnt),
    .res_o     (res)
  );

  stdf_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .push_cnt_i (res_cnt),
    .push_res_i (res),
    .ready_o    (s_axis_tready),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_res_o    (m_res)
  );

  assign m_axis_tdata = {6'd0, m_res.status, m_res.out_byte};
  assign m_axis_tlast = m_res.is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase   <= PH_HEADER;
      st_q.hdr_cnt <= 2'd0;
      st_q.rem     <= 33'd0;
      st_q.kind    <= KIND_PLAIN;
      st_q.tshift  <= 32'd0;
      max_len_q    <= MaxPlainReset;
    end else begin
      if (accept) begin
        st_q <= st_d;
      end
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
    end
  end

  // header bytes need no reset, they are read only once all four are written
  always_ff @(posedge clk_i) begin
    if (accept && hdr_we) begin
      hdr_q[st_q.hdr_cnt] <= s_axis_tdata;
    end
  end

  a_hdr_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.phase != PH_HEADER) |-> (st_q.hdr_cnt == 2'd0))
    else $error("header count left over outside header phase");

  a_body_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.phase == PH_BODY) |-> (st_q.rem != 33'd0))
    else $error("body phase with nothing remaining");

  a_header_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (res_cnt == 3'd4)) |=> (st_q.phase == PH_FIFTH))
    else $error("header burst not followed by fifth byte phase");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the security token deframer, driven over its byte stream ports
module tb;
  import stdf_pkg::*;

  localparam int QuietLimit  = 1000;
  localparam int DrainCycles = 8;
  localparam int HoldCycles  = 60;

  typedef enum logic [1:0] {
    CHK_MODEL = 2'd0,
    CHK_NONE  = 2'd1,
    CHK_ONE   = 2'd2
  } row_chk_e;

  typedef struct packed {
    logic [7:0] b;
    logic       e;
    row_chk_e   chk;
    status_e    st;
  } row_t;

  typedef struct packed {
    logic [7:0] b;
    logic       e;
  } stream_item_t;

  // directed rows; a typed row always means one result with byte 0 and is_last set
  localparam row_t DirRows [27] = '{
    '{8'h5a, 1'b1, CHK_NONE,  ST_BYTE},   // end at a token boundary
    '{8'h00, 1'b0, CHK_NONE,  ST_BYTE},   // zero plain length
    '{8'h00, 1'b0, CHK_NONE,  ST_BYTE},
    '{8'h00, 1'b0, CHK_NONE,  ST_BYTE},
    '{8'h00, 1'b0, CHK_ONE,   ST_EMPTY},
    '{8'h01, 1'b0, CHK_NONE,  ST_BYTE},   // one above the reset limit
    '{8'h00, 1'b0, CHK_NONE,  ST_BYTE},
    '{8'h00, 1'b0, CHK_NONE,  ST_BYTE},
    '{8'h01, 1'b0, CHK_ONE,   ST_BAD},
    '{8'h80, 1'b0, CHK_NONE,  ST_BYTE},   // sslv2 hello, length two
    '{8'h02, 1'b0, CHK_NONE,  ST_BYTE},
    '{8'h01, 1'b0, CHK_NONE,  ST_BYTE},
    '{8'hc3, 1'b0, CHK_ONE,   ST_BAD},
    '{8'h17, 1'b0, CHK_NONE,  ST_BYTE},   // end while header bytes are buffered
    '{8'h03, 1'b0, CHK_NONE,  ST_BYTE},
    '{8'ha5, 1'b1, CHK_ONE,   ST_EARLY},
    '{8'h16, 1'b0, CHK_MODEL, ST_BYTE},   // tls record, empty body
    '{8'h03, 1'b0, CHK_MODEL, ST_BYTE},
    '{8'h01, 1'b0, CHK_MODEL, ST_BYTE},
    '{8'h00, 1'b0, CHK_MODEL, ST_BYTE},
    '{8'h00, 1'b0, CHK_MODEL, ST_BYTE},
    '{8'h00, 1'b0, CHK_NONE,  ST_BYTE},   // end inside a plain body
    '{8'h00, 1'b0, CHK_NONE,  ST_BYTE},
    '{8'h00, 1'b0, CHK_NONE,  ST_BYTE},
    '{8'h05, 1'b0, CHK_NONE,  ST_BYTE},
    '{8'hff, 1'b0, CHK_MODEL, ST_BYTE},
    '{8'h3c, 1'b1, CHK_ONE,   ST_EARLY}
  };

  logic        clk = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  // predictor state
  phase_e      ph;
  logic [7:0]  hdr_buf [4];
  int unsigned hdr_cnt;
  logic [32:0] left;
  kind_e       kind;
  logic [31:0] tshift;
  logic [31:0] max_len;

  res_t         step_out [$];
  res_t         due_q [$];
  stream_item_t burst [$];

  int  src_idle;
  int  snk_idle;
  bit  hold_req;
  int  hold_left;
  int  quiet;
  int  mismatches;

  always #6 clk = ~clk;

  security_token_deframer u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  function automatic void put_res(logic [7:0] b, logic last, status_e st);
    res_t r;
    r.out_byte = b;
    r.is_last  = last;
    r.status   = st;
    step_out.push_back(r);
  endfunction

  function automatic void to_header();
    ph      = PH_HEADER;
    hdr_cnt = 0;
  endfunction

  // four buffered header bytes decide the record kind
  function automatic void classify_header();
    logic [31:0] plen;
    logic [14:0] len2;
    plen = {hdr_buf[0], hdr_buf[1], hdr_buf[2], hdr_buf[3]};
    len2 = {hdr_buf[0][6:0], hdr_buf[1]};
    if (hdr_buf[0] >= RecTypeLo && hdr_buf[0] <= RecTypeHi &&
        (hdr_buf[1] == 8'd3 || (hdr_buf[1] == 8'd2 && hdr_buf[2] == 8'd0))) begin
      kind = (hdr_buf[0] == RecTypeT26) ? KIND_T26 : KIND_SSL3;
    end else if (hdr_buf[0][7] && hdr_buf[2] == 8'd1) begin
      if (len2 < Ssl2Overhead) begin
        to_header();
        put_res(8'h00, 1'b1, ST_BAD);
        return;
      end
      kind = KIND_SSL2;
    end else begin
      kind = KIND_PLAIN;
      if (plen > max_len) begin
        to_header();
        put_res(8'h00, 1'b1, ST_BAD);
      end else if (plen == 32'd0) begin
        to_header();
        put_res(8'h00, 1'b1, ST_EMPTY);
      end else begin
        left = {1'b0, plen};
        ph   = PH_BODY;
      end
      return;
    end
    for (int i = 0; i < 4; i++) put_res(hdr_buf[i], 1'b0, ST_BYTE);
    ph = PH_FIFTH;
  endfunction

  // works out the results that one accepted item causes
  function automatic void deframe_byte(logic [7:0] b, logic e);
    logic [32:0] dsize;
    step_out.delete();
    if (e) begin
      if (ph == PH_HEADER && hdr_cnt == 0) return;
      to_header();
      put_res(8'h00, 1'b1, ST_EARLY);
      return;
    end
    case (ph)
      PH_HEADER: begin
        hdr_buf[hdr_cnt] = b;
        hdr_cnt++;
        if (hdr_cnt == 4) begin
          hdr_cnt = 0;
          classify_header();
        end
      end
      PH_FIFTH: begin
        if (kind == KIND_SSL2)
          dsize = {18'd0, hdr_buf[0][6:0], hdr_buf[1]} - {18'd0, Ssl2Overhead};
        else
          dsize = {17'd0, hdr_buf[3], b};
        if (kind == KIND_T26) begin
          left   = dsize + TrailerLen;
          tshift = 32'd0;
          ph     = PH_TRAILER;
          put_res(b, 1'b0, ST_BYTE);
        end else if (dsize == 33'd0) begin
          to_header();
          put_res(b, 1'b1, ST_BYTE);
        end else begin
          left = dsize;
          ph   = PH_BODY;
          put_res(b, 1'b0, ST_BYTE);
        end
      end
      PH_TRAILER: begin
        // the last four trailer bytes carry a further body length
        if (left <= 33'd4) tshift = {tshift[23:0], b};
        left = left - 33'd1;
        if (left != 33'd0) begin
          put_res(b, 1'b0, ST_BYTE);
        end else if (tshift == 32'd0) begin
          to_header();
          put_res(b, 1'b1, ST_BYTE);
        end else begin
          left = {1'b0, tshift};
          ph   = PH_BODY;
          put_res(b, 1'b0, ST_BYTE);
        end
      end
      default: begin
        if (left <= 33'd1) begin
          left = 33'd0;
          to_header();
          put_res(b, 1'b1, ST_BYTE);
        end else begin
          left = left - 33'd1;
          put_res(b, 1'b0, ST_BYTE);
        end
      end
    endcase
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic void push_byte(logic [7:0] b);
    stream_item_t it;
    it.b = b;
    it.e = 1'b0;
    burst.push_back(it);
  endfunction

  function automatic void push_len(logic [31:0] len);
    for (int i = 3; i >= 0; i--) push_byte(len[8*i +: 8]);
  endfunction

  // one token with random content, at times with a bad length, sometimes cut short, or a little noise
  function automatic void make_token();
    int          pick;
    int          n;
    int          cut;
    logic [31:0] len;
    logic [7:0]  ver1;
    logic [7:0]  ver2;
    stream_item_t tail;
    burst.delete();
    pick = $urandom_range(99);
    if ($urandom_range(1)) begin
      ver1 = 8'd3;
      ver2 = 8'($urandom);
    end else begin
      ver1 = 8'd2;
      ver2 = 8'd0;
    end
    if (pick >= 90) begin
      n = $urandom_range(3);
      repeat (n) push_byte(8'($urandom));
    end else begin
      case ($urandom_range(3))
        0: begin
          len = ($urandom_range(99) < 85) ? $urandom_range(8) : $urandom_range(40, 9);
          if (max_len < 32'hffff_fff0 && $urandom_range(9) == 0)
            len = max_len + 32'd1 + $urandom_range(3);
          push_len(len);
          if (len != 32'd0 && len <= max_len) repeat (len) push_byte(8'($urandom));
        end
        1: begin
          n = $urandom_range(6);
          push_byte(8'($urandom_range(25, 20)));
          push_byte(ver1);
          push_byte(ver2);
          push_byte(8'h00);
          push_byte(8'(n));
          repeat (n) push_byte(8'($urandom));
        end
        2: begin
          n = $urandom_range(10);
          push_byte(8'h80);
          push_byte(8'(n));
          push_byte(8'h01);
          push_byte(8'($urandom));
          if (n >= 3) repeat (n - 2) push_byte(8'($urandom));
        end
        default: begin
          n   = $urandom_range(2);
          len = $urandom_range(5);
          push_byte(RecTypeT26);
          push_byte(ver1);
          push_byte(ver2);
          push_byte(8'h00);
          push_byte(8'(n));
          repeat (n + 8) push_byte(8'($urandom));
          push_len(len);
          repeat (len) push_byte(8'($urandom));
        end
      endcase
      if (pick < 75 || burst.size() < 2) return;
      cut   = $urandom_range(burst.size() - 1, 1);
      burst = burst[0:cut-1];
    end
    tail.b = 8'($urandom);
    tail.e = 1'b1;
    burst.push_back(tail);
  endfunction

  task automatic send_item(logic [7:0] b, logic e, row_chk_e chk, status_e st);
    res_t r;
    @(negedge clk);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= e;
    do @(posedge clk); while (!s_axis_tready);
    deframe_byte(b, e);
    if (chk == CHK_MODEL) begin
      foreach (step_out[i]) due_q.push_back(step_out[i]);
    end else if (chk == CHK_ONE) begin
      r.out_byte = 8'h00;
      r.is_last  = 1'b1;
      r.status   = st;
      due_q.push_back(r);
    end
  endtask

  task automatic send_burst(output int sent);
    sent = 0;
    foreach (burst[i]) begin
      send_item(burst[i].b, burst[i].e, CHK_MODEL, ST_BYTE);
      if (!burst[i].e) sent++;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_max_len(logic [31:0] v);
    @(negedge clk);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk);
    max_len = v;
    @(negedge clk);
    cfg_we_i <= 1'b0;
  endtask

  task automatic new_setting(int src, int snk, logic [31:0] v);
    wait_drained();
    src_idle = src;
    snk_idle = snk;
    write_max_len(v);
  endtask

  task automatic random_items(int target);
    int total;
    int sent;
    total = 0;
    while (total < target) begin
      make_token();
      send_burst(sent);
      total += sent;
    end
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle);
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.out_byte = m_axis_tdata[7:0];
      got.is_last  = m_axis_tlast;
      got.status   = status_e'(m_axis_tdata[9:8]);
      if (due_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result byte %02h status %0d last %b",
                                got.out_byte, got.status, got.is_last));
      end else begin
        want = due_q.pop_front();
        if (got != want || m_axis_tdata[15:10] != 6'd0)
          note_mismatch($sformatf(
              "expected byte %02h status %0d last %b, got byte %02h status %0d last %b pad %02h",
              want.out_byte, want.status, want.is_last, got.out_byte, got.status,
              got.is_last, m_axis_tdata[15:10]));
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QuietLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 32'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    hold_req      = 1'b0;
    hold_left     = 0;
    quiet         = 0;
    mismatches    = 0;
    src_idle      = 11;
    snk_idle      = 67;
    max_len       = MaxPlainReset;
    left          = 33'd0;
    kind          = KIND_PLAIN;
    tshift        = 32'd0;
    to_header();
    repeat (10) @(negedge clk);
    rst_ni = 1'b1;

    foreach (DirRows[i]) send_item(DirRows[i].b, DirRows[i].e, DirRows[i].chk, DirRows[i].st);

    new_setting(11, 67, 32'd16);
    random_items(30);
    new_setting(67, 11, 32'd0);
    random_items(30);

    // receiver holds off while a long plain token keeps coming, so the input backs up
    new_setting(0, 0, 32'hffff_ffff);
    hold_req = 1'b1;
    burst.delete();
    push_len(32'd24);
    repeat (24) push_byte(8'($urandom));
    send_burst(sent);
    random_items(30);

    wait_drained();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
